// File: src/ness_pkg.sv
// Shared types, constants and helpers for the note event sequence sorter.
package ness_pkg;

   localparam int TRACKS           = 4;
   localparam int EVENTS_PER_TRACK = 64;

   localparam int TRK_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
   localparam int FILL_W = $clog2(EVENTS_PER_TRACK + 1);
   localparam int ADDR_W = (TRACKS * EVENTS_PER_TRACK > 1) ? $clog2(TRACKS * EVENTS_PER_TRACK) : 1;
   localparam int ENTRY_W = 55;

   localparam logic [7:0]  NOTE_ON     = 8'h90;
   localparam logic [7:0]  NOTE_OFF    = 8'h80;
   localparam logic [6:0]  MAX_NOTE    = 7'd127;
   localparam logic [4:0]  MAX_CHANNEL = 5'd16;
   localparam logic [8:0]  TOTAL_MAX   = 9'd511;
   localparam logic [31:0] TICK_MAX    = 32'hFFFF_FFFF;

   localparam logic [1:0] CMD_ADD  = 2'd0;
   localparam logic [1:0] CMD_SORT = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   typedef enum logic [2:0] {
      ST_ADDED     = 3'd0,
      ST_BAD_TRACK = 3'd1,
      ST_FULL      = 3'd2,
      ST_SORTED    = 3'd3,
      ST_EVENT     = 3'd4,
      ST_NO_EVENT  = 3'd5
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       wr_on;
      logic       wr_off;
      logic       sort_begin;
      logic       trk_init;
      logic       rd_cur;
      logic       get_cur;
      logic       shift;
      logic       put;
      logic       next_track;
      logic       rd_event;
      logic       respond;
      status_type status;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] cmd;
      logic       track_ok;
      logic       track_full;
      logic       read_ok;
      logic       fill_le1;
      logic       last_i;
      logic       goes_first;
      logic       j_one;
      logic       last_track;
   } stat_type;

   function automatic logic [ADDR_W-1:0] mem_addr(input logic [TRK_W-1:0] t,
                                                  input logic [FILL_W-1:0] x);
      mem_addr = ADDR_W'(int'(t) * EVENTS_PER_TRACK + int'(x));
   endfunction

endpackage

// File: src/ness_dpath.sv
// Datapath: event memory, track fills, song length, totals and sort counters.
module ness_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  ness_pkg::ctl_type    ctl,
   output ness_pkg::stat_type   stat,
   input  logic [1:0]           req_cmd,
   input  logic [2:0]           req_track,
   input  logic [4:0]           req_midi_channel,
   input  logic [7:0]           req_pitch,
   input  logic [7:0]           req_note_velocity,
   input  logic [31:0]          req_start_tick,
   input  logic [31:0]          req_end_tick,
   input  logic [5:0]           req_event_index,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_status_code,
   output logic [31:0]          rsp_event_time,
   output logic [7:0]           rsp_event_status_byte,
   output logic [6:0]           rsp_event_note,
   output logic [7:0]           rsp_event_velocity,
   output logic [6:0]           rsp_track_event_count,
   output logic [31:0]          rsp_song_length,
   output logic [8:0]           rsp_event_total
);

   logic [1:0]  cmd_ff;
   logic [2:0]  trk_ff;
   logic [4:0]  chan_ff;
   logic [7:0]  pitch_ff;
   logic [7:0]  vel_ff;
   logic [31:0] start_ff;
   logic [31:0] end_ff;
   logic [5:0]  idx_ff;

   logic [ness_pkg::FILL_W-1:0] fill_ff [ness_pkg::TRACKS];
   logic [31:0] length_ff;
   logic [8:0]  total_ff;
   logic [ness_pkg::TRK_W-1:0]  st_ff;
   logic [ness_pkg::FILL_W-1:0] i_ff;
   logic [ness_pkg::FILL_W-1:0] j_ff;
   logic [ness_pkg::ENTRY_W-1:0] cur_ff;
   logic [ness_pkg::ENTRY_W-1:0] rdata_ff;
   logic [ness_pkg::ENTRY_W-1:0] mem [ness_pkg::TRACKS * ness_pkg::EVENTS_PER_TRACK];

   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [31:0] rsp_time_ff;
   logic [7:0]  rsp_sbyte_ff;
   logic [6:0]  rsp_note_ff;
   logic [7:0]  rsp_vel_ff;
   logic [6:0]  rsp_count_ff;
   logic [31:0] rsp_length_ff;
   logic [8:0]  rsp_total_ff;

   logic [ness_pkg::TRK_W-1:0]  trk;
   logic                        track_ok;
   logic [ness_pkg::FILL_W-1:0] fill_cur;
   logic [ness_pkg::FILL_W-1:0] fill_st;
   logic [3:0]  ch;
   logic [6:0]  note;
   logic [7:0]  vel;
   logic [31:0] safe_end;
   logic [31:0] start_inc;
   logic [9:0]  total_sum;
   logic        we;
   logic [ness_pkg::ADDR_W-1:0]  waddr;
   logic [ness_pkg::ADDR_W-1:0]  raddr;
   logic [ness_pkg::ENTRY_W-1:0] wdata;

   assign trk      = trk_ff[ness_pkg::TRK_W-1:0];
   assign track_ok = {1'b0, trk_ff} < 4'(ness_pkg::TRACKS);
   assign fill_cur = fill_ff[trk];
   assign fill_st  = fill_ff[st_ff];

   always_comb begin
      if (chan_ff == 5'd0) begin
         ch = 4'd0;
      end else if (chan_ff > ness_pkg::MAX_CHANNEL) begin
         ch = 4'd15;
      end else begin
         ch = 4'(chan_ff - 5'd1);
      end
      note      = (pitch_ff > 8'(ness_pkg::MAX_NOTE)) ? ness_pkg::MAX_NOTE : pitch_ff[6:0];
      vel       = (vel_ff == 8'd0) ? 8'd1 : vel_ff;
      start_inc = (start_ff == ness_pkg::TICK_MAX) ? ness_pkg::TICK_MAX : start_ff + 32'd1;
      safe_end  = (end_ff > start_inc) ? end_ff : start_inc;
      total_sum = {1'b0, total_ff} + 10'd2;
   end

   always_comb begin
      stat.cmd        = cmd_ff;
      stat.track_ok   = track_ok;
      stat.track_full = ({1'b0, fill_cur} + (ness_pkg::FILL_W+1)'(2))
                        > (ness_pkg::FILL_W+1)'(ness_pkg::EVENTS_PER_TRACK);
      stat.read_ok    = track_ok && ({1'b0, idx_ff} < 7'(fill_cur));
      stat.fill_le1   = fill_st <= ness_pkg::FILL_W'(1);
      stat.last_i     = (i_ff + ness_pkg::FILL_W'(1)) >= fill_st;
      stat.goes_first = (cur_ff[54:23] < rdata_ff[54:23]) ||
                        ((cur_ff[54:23] == rdata_ff[54:23]) &&
                         (cur_ff[22:19] < rdata_ff[22:19]));
      stat.j_one      = j_ff == ness_pkg::FILL_W'(1);
      stat.last_track = st_ff == ness_pkg::TRK_W'(ness_pkg::TRACKS - 1);
   end

   // memory port select
   always_comb begin
      we    = 1'b0;
      waddr = ness_pkg::mem_addr(st_ff, j_ff);
      wdata = cur_ff;
      raddr = ness_pkg::mem_addr(st_ff, i_ff);
      if (ctl.wr_on) begin
         we    = 1'b1;
         waddr = ness_pkg::mem_addr(trk, fill_cur);
         wdata = {start_ff, ness_pkg::NOTE_ON | {4'd0, ch}, note, vel};
      end else if (ctl.wr_off) begin
         we    = 1'b1;
         waddr = ness_pkg::mem_addr(trk, fill_cur + ness_pkg::FILL_W'(1));
         wdata = {safe_end, ness_pkg::NOTE_OFF | {4'd0, ch}, note, 8'd0};
      end else if (ctl.shift) begin
         we    = 1'b1;
         wdata = rdata_ff;
      end else if (ctl.put) begin
         we    = 1'b1;
      end
      if (ctl.rd_event) begin
         raddr = ness_pkg::mem_addr(trk, ness_pkg::FILL_W'(idx_ff));
      end else if (ctl.rd_cur) begin
         raddr = ness_pkg::mem_addr(st_ff, i_ff);
      end else if (ctl.get_cur) begin
         raddr = ness_pkg::mem_addr(st_ff, i_ff - ness_pkg::FILL_W'(1));
      end else if (ctl.shift) begin
         raddr = ness_pkg::mem_addr(st_ff, j_ff - ness_pkg::FILL_W'(2));
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff   <= req_cmd;
         trk_ff   <= req_track;
         chan_ff  <= req_midi_channel;
         pitch_ff <= req_pitch;
         vel_ff   <= req_note_velocity;
         start_ff <= req_start_tick;
         end_ff   <= req_end_tick;
         idx_ff   <= req_event_index;
      end
      if (ctl.sort_begin) begin
         st_ff <= '0;
      end else if (ctl.next_track) begin
         st_ff <= st_ff + ness_pkg::TRK_W'(1);
      end
      if (ctl.trk_init) begin
         i_ff <= ness_pkg::FILL_W'(1);
      end else if (ctl.put) begin
         i_ff <= i_ff + ness_pkg::FILL_W'(1);
      end
      if (ctl.get_cur) begin
         j_ff   <= i_ff;
         cur_ff <= rdata_ff;
      end else if (ctl.shift) begin
         j_ff <= j_ff - ness_pkg::FILL_W'(1);
      end
      if (ctl.respond) begin
         rsp_status_ff <= 3'(ctl.status);
         if (ctl.status == ness_pkg::ST_EVENT) begin
            rsp_time_ff  <= rdata_ff[54:23];
            rsp_sbyte_ff <= rdata_ff[22:15];
            rsp_note_ff  <= rdata_ff[14:8];
            rsp_vel_ff   <= rdata_ff[7:0];
         end else begin
            rsp_time_ff  <= '0;
            rsp_sbyte_ff <= '0;
            rsp_note_ff  <= '0;
            rsp_vel_ff   <= '0;
         end
         rsp_count_ff  <= track_ok ? 7'(fill_cur) : 7'd0;
         rsp_length_ff <= length_ff;
         rsp_total_ff  <= total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < ness_pkg::TRACKS; t++) begin
            fill_ff[t] <= '0;
         end
         length_ff    <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.respond;
         if (ctl.wr_off) begin
            fill_ff[trk] <= fill_cur + ness_pkg::FILL_W'(2);
            if (safe_end > length_ff) begin
               length_ff <= safe_end;
            end
            total_ff <= (total_sum > {1'b0, ness_pkg::TOTAL_MAX}) ?
                        ness_pkg::TOTAL_MAX : total_sum[8:0];
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status_code       = rsp_status_ff;
   assign rsp_event_time        = rsp_time_ff;
   assign rsp_event_status_byte = rsp_sbyte_ff;
   assign rsp_event_note        = rsp_note_ff;
   assign rsp_event_velocity    = rsp_vel_ff;
   assign rsp_track_event_count = rsp_count_ff;
   assign rsp_song_length       = rsp_length_ff;
   assign rsp_event_total       = rsp_total_ff;

endmodule

// File: src/ness_ctrl.sv
// Controller: command decode and insertion-sort sequencer.
module ness_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  ness_pkg::stat_type  stat,
   output ness_pkg::ctl_type   ctl
);

   typedef enum logic [3:0] {
      IDLE, DECODE, ADD_OFF, RESP_ADD, SORT_TRK, SORT_RD, SORT_GET,
      SORT_CMP, SORT_PUT, READ_WAIT
   } state_type;

   state_type state_ff, state_in;

   assign busy = state_ff != IDLE;

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               ctl.capture = 1'b1;
               state_in    = DECODE;
            end
         end
         DECODE: begin
            priority if (stat.cmd == ness_pkg::CMD_ADD) begin
               if (!stat.track_ok) begin
                  ctl.respond = 1'b1;
                  ctl.status  = ness_pkg::ST_BAD_TRACK;
                  state_in    = IDLE;
               end else if (stat.track_full) begin
                  ctl.respond = 1'b1;
                  ctl.status  = ness_pkg::ST_FULL;
                  state_in    = IDLE;
               end else begin
                  ctl.wr_on = 1'b1;
                  state_in  = ADD_OFF;
               end
            end else if (stat.cmd == ness_pkg::CMD_SORT) begin
               ctl.sort_begin = 1'b1;
               state_in       = SORT_TRK;
            end else if (stat.cmd == ness_pkg::CMD_READ && stat.read_ok) begin
               ctl.rd_event = 1'b1;
               state_in     = READ_WAIT;
            end else begin
               ctl.respond = 1'b1;
               ctl.status  = ness_pkg::ST_NO_EVENT;
               state_in    = IDLE;
            end
         end
         ADD_OFF: begin
            ctl.wr_off = 1'b1;
            state_in   = RESP_ADD;
         end
         RESP_ADD: begin
            ctl.respond = 1'b1;
            ctl.status  = ness_pkg::ST_ADDED;
            state_in    = IDLE;
         end
         SORT_TRK: begin
            if (stat.fill_le1) begin
               if (stat.last_track) begin
                  ctl.respond = 1'b1;
                  ctl.status  = ness_pkg::ST_SORTED;
                  state_in    = IDLE;
               end else begin
                  ctl.next_track = 1'b1;
               end
            end else begin
               ctl.trk_init = 1'b1;
               state_in     = SORT_RD;
            end
         end
         SORT_RD: begin
            ctl.rd_cur = 1'b1;
            state_in   = SORT_GET;
         end
         SORT_GET: begin
            ctl.get_cur = 1'b1;
            state_in    = SORT_CMP;
         end
         SORT_CMP, SORT_PUT: begin
            if (state_ff == SORT_CMP && stat.goes_first) begin
               // move the later word up one slot
               ctl.shift = 1'b1;
               state_in  = stat.j_one ? SORT_PUT : SORT_CMP;
            end else begin
               ctl.put = 1'b1;
               if (!stat.last_i) begin
                  state_in = SORT_RD;
               end else if (stat.last_track) begin
                  ctl.respond = 1'b1;
                  ctl.status  = ness_pkg::ST_SORTED;
                  state_in    = IDLE;
               end else begin
                  ctl.next_track = 1'b1;
                  state_in       = SORT_TRK;
               end
            end
         end
         READ_WAIT: begin
            ctl.respond = 1'b1;
            ctl.status  = ness_pkg::ST_EVENT;
            state_in    = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/note_event_sequence_sorter.sv
// Top level of the note event sequence sorter: controller plus datapath.
// Add: note-on write, note-off write, then result strobe; bad track, full, bad read
// answer from decode, a read after the memory read. Sort: insertion sort per track
// in the two-port event memory; busy stays high until the result strobe.
// One word at a time; a new start is taken in the cycle the result strobe shows.
// Synchronous reset clears fills, song length and total; event memory is not cleared.
module note_event_sequence_sorter (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [2:0]  req_track,
   input  logic [4:0]  req_midi_channel,
   input  logic [7:0]  req_pitch,
   input  logic [7:0]  req_note_velocity,
   input  logic [31:0] req_start_tick,
   input  logic [31:0] req_end_tick,
   input  logic [5:0]  req_event_index,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status_code,
   output logic [31:0] rsp_event_time,
   output logic [7:0]  rsp_event_status_byte,
   output logic [6:0]  rsp_event_note,
   output logic [7:0]  rsp_event_velocity,
   output logic [6:0]  rsp_track_event_count,
   output logic [31:0] rsp_song_length,
   output logic [8:0]  rsp_event_total
);

   ness_pkg::ctl_type  ctl;
   ness_pkg::stat_type stat;

   ness_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctl   (ctl)
   );

   ness_dpath u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .ctl                   (ctl),
      .stat                  (stat),
      .req_cmd               (req_cmd),
      .req_track             (req_track),
      .req_midi_channel      (req_midi_channel),
      .req_pitch             (req_pitch),
      .req_note_velocity     (req_note_velocity),
      .req_start_tick        (req_start_tick),
      .req_end_tick          (req_end_tick),
      .req_event_index       (req_event_index),
      .rsp_valid             (rsp_valid),
      .rsp_status_code       (rsp_status_code),
      .rsp_event_time        (rsp_event_time),
      .rsp_event_status_byte (rsp_event_status_byte),
      .rsp_event_note        (rsp_event_note),
      .rsp_event_velocity    (rsp_event_velocity),
      .rsp_track_event_count (rsp_track_event_count),
      .rsp_song_length       (rsp_song_length),
      .rsp_event_total       (rsp_event_total)
   );

endmodule

// File: tb/sv/note_event_sequence_sorter_checker.sv
// Scoreboard for the note event sequence sorter: predicts each response word and compares it.
module note_event_sequence_sorter_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [2:0]  req_track,
   input  logic [4:0]  req_midi_channel,
   input  logic [7:0]  req_pitch,
   input  logic [7:0]  req_note_velocity,
   input  logic [31:0] req_start_tick,
   input  logic [31:0] req_end_tick,
   input  logic [5:0]  req_event_index,
   input  logic        rsp_valid,
   input  logic [2:0]  rsp_status_code,
   input  logic [31:0] rsp_event_time,
   input  logic [7:0]  rsp_event_status_byte,
   input  logic [6:0]  rsp_event_note,
   input  logic [7:0]  rsp_event_velocity,
   input  logic [6:0]  rsp_track_event_count,
   input  logic [31:0] rsp_song_length,
   input  logic [8:0]  rsp_event_total,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [31:0] tick;
      logic [7:0]  stat;
      logic [6:0]  note;
      logic [7:0]  vel;
   } note_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] ev_time;
      logic [7:0]  ev_stat;
      logic [6:0]  ev_note;
      logic [7:0]  ev_vel;
      logic [6:0]  count;
      logic [31:0] length;
      logic [8:0]  total;
   } rsp_word_type;

   note_word_type notes [ness_pkg::TRACKS][ness_pkg::EVENTS_PER_TRACK];
   int            fill [ness_pkg::TRACKS];
   logic [31:0]   song_len;
   logic [8:0]    ev_total;
   rsp_word_type  expected_q[$];

   function automatic bit earlier(note_word_type a, note_word_type b);
      if (a.tick != b.tick) return a.tick < b.tick;
      return (a.stat & 8'hf0) < (b.stat & 8'hf0);
   endfunction

   task automatic sort_notes(int t);
      note_word_type cur;
      int j;
      for (int i = 1; i < fill[t]; i++) begin
         cur = notes[t][i];
         j = i;
         while (j > 0 && earlier(cur, notes[t][j-1])) begin
            notes[t][j] = notes[t][j-1];
            j--;
         end
         notes[t][j] = cur;
      end
   endtask

   task automatic predict_word();
      rsp_word_type r;
      logic [4:0]  ch;
      logic [6:0]  nt;
      logic [7:0]  vl;
      logic [31:0] off_tick;
      int t;
      bit ok;
      r = '0;
      t = int'(req_track);
      ok = t < ness_pkg::TRACKS;
      r.status = ness_pkg::ST_NO_EVENT;
      if (req_cmd == ness_pkg::CMD_ADD) begin
         if (!ok) r.status = ness_pkg::ST_BAD_TRACK;
         else if (fill[t] + 2 > ness_pkg::EVENTS_PER_TRACK) r.status = ness_pkg::ST_FULL;
         else begin
            ch = req_midi_channel;
            if (ch < 5'd1) ch = 5'd1;
            if (ch > ness_pkg::MAX_CHANNEL) ch = ness_pkg::MAX_CHANNEL;
            ch = ch - 5'd1;
            nt = (req_pitch > 8'd127) ? ness_pkg::MAX_NOTE : req_pitch[6:0];
            vl = (req_note_velocity == 8'd0) ? 8'd1 : req_note_velocity;
            off_tick = (req_start_tick == ness_pkg::TICK_MAX) ? ness_pkg::TICK_MAX
                                                              : req_start_tick + 32'd1;
            if (req_end_tick > off_tick) off_tick = req_end_tick;
            notes[t][fill[t]]   = '{req_start_tick, ness_pkg::NOTE_ON | {4'd0, ch[3:0]}, nt, vl};
            notes[t][fill[t]+1] = '{off_tick, ness_pkg::NOTE_OFF | {4'd0, ch[3:0]}, nt, 8'd0};
            fill[t] += 2;
            if (off_tick > song_len) song_len = off_tick;
            ev_total = (10'(ev_total) + 10'd2 > 10'(ness_pkg::TOTAL_MAX)) ?
                       ness_pkg::TOTAL_MAX : ev_total + 9'd2;
            r.status = ness_pkg::ST_ADDED;
         end
      end else if (req_cmd == ness_pkg::CMD_SORT) begin
         for (int k = 0; k < ness_pkg::TRACKS; k++) sort_notes(k);
         r.status = ness_pkg::ST_SORTED;
      end else if (req_cmd == ness_pkg::CMD_READ && ok && req_event_index < fill[t]) begin
         r.ev_time = notes[t][req_event_index].tick;
         r.ev_stat = notes[t][req_event_index].stat;
         r.ev_note = notes[t][req_event_index].note;
         r.ev_vel  = notes[t][req_event_index].vel;
         r.status  = ness_pkg::ST_EVENT;
      end
      r.count  = ok ? 7'(fill[t]) : 7'd0;
      r.length = song_len;
      r.total  = ev_total;
      expected_q = {expected_q, r};
   endtask

   always @(posedge clock) begin
      rsp_word_type got, exp_w;
      if (reset) begin
         for (int k = 0; k < ness_pkg::TRACKS; k++) fill[k] = 0;
         song_len = '0;
         ev_total = '0;
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            got = '{rsp_status_code, rsp_event_time, rsp_event_status_byte, rsp_event_note,
                    rsp_event_velocity, rsp_track_event_count, rsp_song_length,
                    rsp_event_total};
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected response word %h", got);
            end else begin
               exp_w = expected_q.pop_front();
               if (got !== exp_w) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch: expected st=%0d t=%h sb=%h n=%0d v=%0d c=%0d l=%h tot=%0d",
                        exp_w.status, exp_w.ev_time, exp_w.ev_stat, exp_w.ev_note,
                        exp_w.ev_vel, exp_w.count, exp_w.length, exp_w.total);
                     $display("          got      st=%0d t=%h sb=%h n=%0d v=%0d c=%0d l=%h tot=%0d",
                        got.status, got.ev_time, got.ev_stat, got.ev_note,
                        got.ev_vel, got.count, got.length, got.total);
                  end
               end
            end
         end
         // response of this edge is checked first, since a new word may start here
         if (start && !busy) predict_word();
      end
      pending = expected_q.size();
   end

endmodule

// File: tb/sv/note_event_sequence_sorter_tb.sv
// Stimulus and verdict for the note event sequence sorter testbench.
module note_event_sequence_sorter_tb;

   logic        clock, reset, start, busy, rsp_valid;
   logic [1:0]  req_cmd;
   logic [2:0]  req_track, rsp_status_code;
   logic [4:0]  req_midi_channel;
   logic [7:0]  req_pitch, req_note_velocity, rsp_event_status_byte, rsp_event_velocity;
   logic [31:0] req_start_tick, req_end_tick, rsp_event_time, rsp_song_length;
   logic [5:0]  req_event_index;
   logic [6:0]  rsp_event_note, rsp_track_event_count;
   logic [8:0]  rsp_event_total;
   int          fail_count, pending;
   int          fills [8];

   note_event_sequence_sorter dut (.*);
   note_event_sequence_sorter_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200000000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [31:0] rand_tick();
      unique case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return ness_pkg::TICK_MAX;
         2: return ness_pkg::TICK_MAX - $urandom_range(0, 3);
         3: return $urandom;
         default: return $urandom_range(0, 40);
      endcase
   endfunction

   // drive one word and hold until it is taken
   task automatic send_word(logic [1:0] c, logic [2:0] t, logic [4:0] ch, logic [7:0] p,
                            logic [7:0] v, logic [31:0] s, logic [31:0] e, logic [5:0] x);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
      repeat (gap) @(negedge clock);
      req_cmd = c; req_track = t; req_midi_channel = ch; req_pitch = p;
      req_note_velocity = v; req_start_tick = s; req_end_tick = e; req_event_index = x;
      start = 1;
      do @(posedge clock); while (busy);
      if (c == ness_pkg::CMD_ADD && t < ness_pkg::TRACKS &&
          fills[t] + 2 <= ness_pkg::EVENTS_PER_TRACK) fills[t] += 2;
      @(negedge clock);
      start = 0;
   endtask

   task automatic random_word(bit full_mix);
      logic [2:0] t;
      int r;
      t = $urandom_range(0, 9) == 0 ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      if (r < 40)
         send_word(ness_pkg::CMD_ADD, t, 5'($urandom), 8'($urandom), 8'($urandom),
                   rand_tick(), rand_tick(), 6'($urandom));
      else if (r < 45)
         send_word(ness_pkg::CMD_SORT, t, 5'($urandom), 8'($urandom), 8'($urandom), $urandom,
                   $urandom, 6'($urandom));
      else if (r < 95 || !full_mix)
         // stay mostly inside the filled range; unwritten entries are never read
         send_word(ness_pkg::CMD_READ, t, 5'($urandom), 8'($urandom), 8'($urandom), $urandom,
                   $urandom, (t < ness_pkg::TRACKS && fills[t] > 0 && $urandom_range(0, 7) != 0) ?
                   6'($urandom_range(0, fills[t] - 1)) :
                   6'(t < ness_pkg::TRACKS ? $urandom_range(fills[t], 63) : $urandom));
      else
         send_word(2'd3, t, 5'($urandom), 8'($urandom), 8'($urandom), $urandom,
                   $urandom, 6'($urandom));
   endtask

   initial begin
      int waited;
      for (int k = 0; k < 8; k++) fills[k] = 0;
      start = 0; req_cmd = ness_pkg::CMD_ADD; req_track = 0; req_midi_channel = 0;
      req_pitch = 0; req_note_velocity = 0; req_start_tick = 0; req_end_tick = 0;
      req_event_index = 0;
      reset = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // clamping extremes, saturated end tick, bad track, equal-tick ordering
      send_word(ness_pkg::CMD_ADD, 0, 0, 8'hff, 0, 32'd10, 32'd0, 0);
      send_word(ness_pkg::CMD_ADD, 0, 31, 8'd0, 8'hff, ness_pkg::TICK_MAX, ness_pkg::TICK_MAX, 0);
      send_word(ness_pkg::CMD_ADD, 0, 16, 8'd127, 8'd1, 32'd5, 32'd11, 0);
      send_word(ness_pkg::CMD_ADD, 0, 1, 8'd128, 8'd128, 32'd11, 32'd20, 0);
      send_word(ness_pkg::CMD_ADD, 7, 5, 8'd60, 8'd64, 32'd1, 32'd2, 0);
      send_word(ness_pkg::CMD_ADD, 4, 5, 8'd60, 8'd64, 32'd1, 32'd2, 0);
      for (int i = 0; i < 8; i++)
         send_word(ness_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 6'(i));
      send_word(ness_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 6'd63);
      send_word(ness_pkg::CMD_READ, 5, 0, 0, 0, 0, 0, 6'd0);
      send_word(2'd3, 0, 0, 0, 0, 0, 0, 0);
      send_word(ness_pkg::CMD_SORT, 0, 0, 0, 0, 0, 0, 0);
      for (int i = 0; i < 8; i++)
         send_word(ness_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 6'(i));

      // random traffic; fills run out, then full tracks get exercised
      for (int n = 0; n < 1800; n++) random_word(1'b1);
      for (int k = 0; k < ness_pkg::TRACKS; k++)
         send_word(ness_pkg::CMD_READ, 3'(k), 0, 0, 0, 0, 0, 6'd63);

      waited = 0;
      while (pending != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

// File: files.f
src/ness_pkg.sv
src/ness_dpath.sv
src/ness_ctrl.sv
src/note_event_sequence_sorter.sv
tb/sv/note_event_sequence_sorter_checker.sv
tb/sv/note_event_sequence_sorter_tb.sv
